### hw/rtl/bipolar_pwm_with_dead_band_assert.svh
// ----------------------------------------------------------------------------
// Bipolar PWM assertion macros
// Clocked assertion helpers for the bipolar PWM block. Each macro expects
// clk and rst_n in scope; checks are off while reset is held.
// ----------------------------------------------------------------------------
`ifndef BIPOLAR_PWM_WITH_DEAD_BAND_ASSERT_SVH
`define BIPOLAR_PWM_WITH_DEAD_BAND_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define BPWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpwm assertion failed");

// Next-cycle implication.
`define BPWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpwm assertion failed");

`else

`define BPWM_ASSERT_NOW(lbl, ante, cons)
`define BPWM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/bpwm_pkg.sv
// ----------------------------------------------------------------------------
// Bipolar PWM package
// Widths, register indexes and reset values shared by the PWM block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package bpwm_pkg;

  localparam int TIME_W     = 24;           // timers and periods
  localparam int DUTY_W     = 16;
  localparam int STEP_W     = 16;
  localparam int MAG_W      = 14;           // holds full scale 10000
  localparam int PROD_W     = TIME_W + MAG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(10000);

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_OPEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_CLOSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_LOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_HIGH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP    = 3'd4;

  localparam logic [TIME_W-1:0] PERIOD_RST = TIME_W'(1000000);
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(1000);

  typedef logic [TIME_W-1:0]        time_t;
  typedef logic signed [DUTY_W-1:0] duty_t;

endpackage

### hw/rtl/bpwm_in_if.sv
// ----------------------------------------------------------------------------
// Bipolar PWM input channel
// Valid/ready channel carrying one signed duty request per tick.
// ----------------------------------------------------------------------------
interface bpwm_in_if;
  logic                 valid;
  logic                 ready;
  bpwm_pkg::duty_t      duty;

  modport source (output valid, output duty, input ready);
  modport sink   (input valid, input duty, output ready);
endinterface

### hw/rtl/bpwm_out_if.sv
// ----------------------------------------------------------------------------
// Bipolar PWM result channel
// Valid/ready channel carrying the open and close output levels of a tick.
// ----------------------------------------------------------------------------
interface bpwm_out_if;
  logic valid;
  logic ready;
  logic pulse_open;
  logic pulse_close;

  modport source (output valid, output pulse_open, output pulse_close, input ready);
  modport sink   (input valid, input pulse_open, input pulse_close, output ready);
endinterface

### hw/rtl/bpwm_cfg_if.sv
// ----------------------------------------------------------------------------
// Bipolar PWM configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bpwm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpwm_pkg::CFG_IDX_W-1:0]       index;
  logic [bpwm_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/bipolar_pwm_with_dead_band.sv
// ----------------------------------------------------------------------------
// Bipolar PWM with dead band
// Turns a stream of signed duty requests into open/close PWM levels, one
// result per request.
// ----------------------------------------------------------------------------
// One request per clock is taken while the output is not stalled; each gives
// one result through the input register, then the result register. The
// throughput of one per cycle is set by the single pass from the input
// register to the result register: dead band and clamp, two 24x14 multiplies
// (timer*10000 and period*|duty|), one compare, and the timer add-and-wrap. A
// new request is taken while a finished result waits at the output. Registers
// are written through the configuration channel, which is always ready; write
// only while the block is idle. Unknown register indexes are ignored.
`include "bipolar_pwm_with_dead_band_assert.svh"

module bipolar_pwm_with_dead_band (
  input  logic        clk,
  input  logic        rst_n,
  bpwm_in_if.sink     in_ch,
  bpwm_out_if.source  out_ch,
  bpwm_cfg_if.sink    cfg_ch
);
  import bpwm_pkg::*;

  // configuration
  time_t                   period_open_r;
  time_t                   period_close_r;
  duty_t                   db_low_r;
  duty_t                   db_high_r;
  logic [STEP_W-1:0]       step_r;

  // input stage
  logic                    s_valid_r;
  duty_t                   s_duty_r;

  // phase timers
  time_t                   open_timer_r, open_timer_nxt;
  time_t                   close_timer_r, close_timer_nxt;

  // result stage
  logic                    out_valid_r;
  logic                    out_open_r, out_close_r;

  logic                    out_free, s_go;
  logic                    in_db, is_pos, is_neg;
  logic [DUTY_W-1:0]       neg_abs;
  logic [MAG_W-1:0]        mag;
  time_t                   act_timer, act_period, new_timer;
  logic [PROD_W-1:0]       lhs, rhs;
  logic [TIME_W:0]         sum;
  logic                    level;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s_go         = s_valid_r && out_free;
  assign in_ch.ready  = !s_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pulse_open  = out_open_r;
  assign out_ch.pulse_close = out_close_r;

  // Dead band, clamp to full scale and pick the active side.
  always_comb begin
    in_db   = (db_low_r < s_duty_r) && (s_duty_r < db_high_r);
    is_pos  = !in_db && (s_duty_r > 0);
    is_neg  = !in_db && (s_duty_r < 0);
    neg_abs = ~s_duty_r + 1'b1;
    if (is_pos) begin
      mag = (s_duty_r >= $signed({2'b00, FULL_SCALE})) ? FULL_SCALE : s_duty_r[MAG_W-1:0];
    end else begin
      mag = (s_duty_r <= -$signed({2'b00, FULL_SCALE})) ? FULL_SCALE : neg_abs[MAG_W-1:0];
    end
    act_timer  = is_pos ? open_timer_r : close_timer_r;
    act_period = is_pos ? period_open_r : period_close_r;
  end

  // Exact fixed-point compare and timer advance.
  always_comb begin
    lhs       = PROD_W'(act_timer) * PROD_W'(FULL_SCALE);
    rhs       = PROD_W'(act_period) * PROD_W'(mag);
    level     = (lhs <= rhs);
    sum       = {1'b0, act_timer} + (TIME_W+1)'(step_r);
    new_timer = (sum >= {1'b0, act_period}) ? '0 : sum[TIME_W-1:0];
  end

  // Clear the idle side, advance the active one.
  always_comb begin
    open_timer_nxt  = open_timer_r;
    close_timer_nxt = close_timer_r;
    if (s_go) begin
      open_timer_nxt  = is_pos ? new_timer : '0;
      close_timer_nxt = is_neg ? new_timer : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_open_r  <= PERIOD_RST;
      period_close_r <= PERIOD_RST;
      db_low_r       <= '0;
      db_high_r      <= '0;
      step_r         <= STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PERIOD_OPEN:  period_open_r  <= cfg_ch.data[TIME_W-1:0];
        CFG_PERIOD_CLOSE: period_close_r <= cfg_ch.data[TIME_W-1:0];
        CFG_DB_LOW:       db_low_r       <= cfg_ch.data[DUTY_W-1:0];
        CFG_DB_HIGH:      db_high_r      <= cfg_ch.data[DUTY_W-1:0];
        CFG_TICK_STEP:    step_r         <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      open_timer_r  <= '0;
      close_timer_r <= '0;
    end else begin
      open_timer_r  <= open_timer_nxt;
      close_timer_r <= close_timer_nxt;
      if (in_ch.valid && in_ch.ready) begin
        s_valid_r <= 1'b1;
      end else if (s_go) begin
        s_valid_r <= 1'b0;
      end
      if (s_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_duty_r <= in_ch.duty;
    end
    if (s_go) begin
      out_open_r  <= is_pos && level;
      out_close_r <= is_neg && level;
    end
  end

  `BPWM_ASSERT_NOW(a_one_side, out_valid_r, !(out_open_r && out_close_r))
  `BPWM_ASSERT_NOW(a_one_timer, open_timer_r != '0, close_timer_r == '0)
  `BPWM_ASSERT_NEXT(a_idle_open_clear, s_go && !is_pos, open_timer_r == '0)
  `BPWM_ASSERT_NEXT(a_hold_request, s_valid_r && out_valid_r && !out_ch.ready, s_valid_r)

endmodule
